[rtl/core/fatlb_pkg.sv]
`timescale 1ns / 1ps

package fatlb_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int PAGE_W    = 20;
  localparam int FRAME_W   = 20;
  localparam int STAMP_W   = 32;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;

  localparam logic [CFG_W-1:0] RESET_IN_USE = 5'd16;
  localparam logic [CFG_W-1:0] RESET_WINDOW = 5'd10;

  typedef struct packed {
    logic load;
    logic match;
    logic scan;
    logic fill;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } status_t;

endpackage

[rtl/core/fatlb_ctrl.sv]
`timescale 1ns / 1ps

module fatlb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  fatlb_pkg::status_t status_i,
  output fatlb_pkg::cmd_t   cmd_o,
  output logic              busy_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_FILL  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = status_i.need_scan ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

[rtl/core/fatlb_dp.sv]
`timescale 1ns / 1ps

module fatlb_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fatlb_pkg::cmd_t                     cmd_i,
  output fatlb_pkg::status_t                  status_o,
  input  logic                                op_i,
  input  logic [fatlb_pkg::PAGE_W-1:0]        virtual_page_i,
  input  logic [fatlb_pkg::FRAME_W-1:0]       frame_number_i,
  input  logic [fatlb_pkg::STAMP_W-1:0]       stamp_i,
  input  logic                                cfg_we_i,
  input  logic [fatlb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fatlb_pkg::CFG_W-1:0]         cfg_data_i,
  output logic                                out_valid_o,
  output logic                                hit_o,
  output logic [fatlb_pkg::FRAME_W-1:0]       frame_o
);

  localparam int N = fatlb_pkg::ENTRIES;

  logic [fatlb_pkg::CFG_W-1:0]   in_use_q, window_q;

  logic                          req_op_q;
  logic [fatlb_pkg::PAGE_W-1:0]  req_page_q;
  logic [fatlb_pkg::FRAME_W-1:0] req_frame_q;
  logic [fatlb_pkg::STAMP_W-1:0] req_stamp_q;

  logic [N-1:0]                  valid_q;
  logic [fatlb_pkg::PAGE_W-1:0]  page_q  [N];
  logic [fatlb_pkg::FRAME_W-1:0] frame_q [N];
  logic [fatlb_pkg::STAMP_W-1:0] stamp_q [N];

  logic [fatlb_pkg::IDX_W-1:0]   scan_idx_q, best_idx_q;
  logic [fatlb_pkg::STAMP_W-1:0] best_stamp_q;
  logic                          found_q;

  logic                          out_valid_q, hit_q;
  logic [fatlb_pkg::FRAME_W-1:0] out_frame_q;

  logic [fatlb_pkg::CNT_W-1:0]   n_act, win_eff, newer_cnt;
  logic [N-1:0]                  in_range, match_vec, free_vec;
  logic                          hit_any, free_any;
  logic [fatlb_pkg::IDX_W-1:0]   hit_idx, free_idx;
  logic [fatlb_pkg::STAMP_W-1:0] cur_stamp;
  logic                          take;

  logic                          wr_en, wr_new;
  logic [fatlb_pkg::IDX_W-1:0]   wr_idx;

  assign n_act   = (in_use_q > fatlb_pkg::CNT_W'(N)) ? fatlb_pkg::CNT_W'(N) : in_use_q;
  assign win_eff = (window_q == '0) ? fatlb_pkg::CNT_W'(1) : window_q;

  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      in_range[i]  = (fatlb_pkg::CNT_W'(i) < n_act);
      match_vec[i] = in_range[i] && valid_q[i] && (page_q[i] == req_page_q);
      free_vec[i]  = in_range[i] && !valid_q[i];
      if (match_vec[i]) begin
        hit_any = 1'b1;
        hit_idx = fatlb_pkg::IDX_W'(i);
      end
      if (free_vec[i]) begin
        free_any = 1'b1;
        free_idx = fatlb_pkg::IDX_W'(i);
      end
    end
  end

  assign cur_stamp = stamp_q[scan_idx_q];

  always_comb begin
    newer_cnt = '0;
    for (int j = 0; j < N; j++) begin
      if (in_range[j] && (stamp_q[j] > cur_stamp)) begin
        newer_cnt = newer_cnt + fatlb_pkg::CNT_W'(1);
      end
    end
  end

  assign take = (newer_cnt < win_eff) && (!found_q || (cur_stamp < best_stamp_q));

  assign status_o.need_scan = req_op_q && (n_act != '0) && !hit_any && !free_any;
  assign status_o.scan_last = ({1'b0, scan_idx_q} == (n_act - fatlb_pkg::CNT_W'(1)));

  always_comb begin
    wr_en  = 1'b0;
    wr_new = 1'b0;
    wr_idx = hit_idx;
    if (cmd_i.match) begin
      if (hit_any) begin
        wr_en = 1'b1;
      end else if (req_op_q && free_any) begin
        wr_en  = 1'b1;
        wr_new = 1'b1;
        wr_idx = free_idx;
      end
    end else if (cmd_i.fill) begin
      wr_en  = 1'b1;
      wr_new = 1'b1;
      wr_idx = best_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q    <= fatlb_pkg::RESET_IN_USE;
      window_q    <= fatlb_pkg::RESET_WINDOW;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_index_i == fatlb_pkg::REG_IN_USE)) begin
        in_use_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == fatlb_pkg::REG_WINDOW)) begin
        window_q <= cfg_data_i;
      end
      if (wr_en && wr_new) begin
        valid_q[wr_idx] <= 1'b1;
      end
      out_valid_q <= cmd_i.match && !req_op_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_op_q    <= op_i;
      req_page_q  <= virtual_page_i;
      req_frame_q <= frame_number_i;
      req_stamp_q <= stamp_i;
    end
    if (wr_en) begin
      stamp_q[wr_idx] <= req_stamp_q;
      if (req_op_q) begin
        frame_q[wr_idx] <= req_frame_q;
      end
      if (wr_new) begin
        page_q[wr_idx] <= req_page_q;
      end
    end
    if (cmd_i.match) begin
      scan_idx_q  <= '0;
      found_q     <= 1'b0;
      hit_q       <= hit_any;
      out_frame_q <= hit_any ? frame_q[hit_idx] : '0;
    end else if (cmd_i.scan) begin
      scan_idx_q <= scan_idx_q + fatlb_pkg::IDX_W'(1);
      if (take) begin
        found_q      <= 1'b1;
        best_idx_q   <= scan_idx_q;
        best_stamp_q <= cur_stamp;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign frame_o     = out_frame_q;

endmodule

[rtl/core/fully_associative_tlb_lru_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Beat
// item      in         start & !busy               op, virtual_page, frame_number, stamp
// result    out        out_valid_o (one cycle)     hit, frame
// config    in         cfg_valid_i & cfg_ready_o   cfg_index_i, cfg_data_i
//
// A lookup, or an insert that hits or finds an empty slot, runs load then match.
// An insert into a full buffer ranks one candidate stamp per cycle against
// all entries in use, scanning each entry in use, then fills the chosen slot.
// A lookup's result strobes in the first cycle with busy low after its match
// cycle. Reset clears all valid bits at once; no clearing pass. The receiver
// cannot stall.

module fully_associative_tlb_lru_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op_i,
  input  logic [fatlb_pkg::PAGE_W-1:0]        virtual_page_i,
  input  logic [fatlb_pkg::FRAME_W-1:0]       frame_number_i,
  input  logic [fatlb_pkg::STAMP_W-1:0]       stamp_i,
  output logic                                out_valid_o,
  output logic                                hit_o,
  output logic [fatlb_pkg::FRAME_W-1:0]       frame_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fatlb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fatlb_pkg::CFG_W-1:0]         cfg_data_i
);

  fatlb_pkg::cmd_t    cmd;
  fatlb_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  fatlb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  fatlb_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .op_i           (op_i),
    .virtual_page_i (virtual_page_i),
    .frame_number_i (frame_number_i),
    .stamp_i        (stamp_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .hit_o          (hit_o),
    .frame_o        (frame_o)
  );

endmodule
